// ===== rtl/core/bbfr_pkg.sv =====
// Shared types, codes and widths for the byte buffer field reader.
package bbfr_pkg;

    localparam int STORE_DEPTH_DEF = 4096;
    localparam int MODE_W          = 3;
    localparam int LADDR_W         = 12;
    localparam int BYTE_W          = 8;
    localparam int VALUE_W         = 32;
    localparam int STATUS_W        = 2;
    localparam int LEN_W           = 13;
    localparam int COUNT_W         = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 3'd0,
        MODE_REWIND = 3'd1,
        MODE_U8     = 3'd2,
        MODE_U16    = 3'd3,
        MODE_U32    = 3'd4,
        MODE_VARINT = 3'd5
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EOB      = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_TOO_LONG = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_DONE
    } t_state;

    localparam logic [COUNT_W-1:0] VARINT_LAST = 3'd4;

endpackage

// ===== rtl/core/bbfr_ifs.sv =====
// Valid/ready channel interfaces for input items, results and configuration writes.
interface bbfr_in_if import bbfr_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [LADDR_W-1:0] load_address;
    logic [BYTE_W-1:0]  load_byte;

    modport source (output valid, output mode, output load_address, output load_byte,
                    input ready);
    modport sink   (input valid, input mode, input load_address, input load_byte,
                    output ready);
endinterface

interface bbfr_out_if import bbfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [VALUE_W-1:0]  read_value;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    cursor_after;

    modport source (output valid, output read_value, output status, output cursor_after,
                    input ready);
    modport sink   (input valid, input read_value, input status, input cursor_after,
                    output ready);
endinterface

interface bbfr_cfg_if import bbfr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/bbfr_store.sv =====
// Single-port byte store with registered read data.
module bbfr_store import bbfr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int AW         = $clog2(STORE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [AW-1:0]     i_addr,
    input  logic [BYTE_W-1:0] i_wdata,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] mem [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bbfr_ctrl.sv =====
// Item sequencer: cursor, byte fetch, field assembly and result register.
module bbfr_ctrl import bbfr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    localparam int AW         = $clog2(STORE_DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LEN_W-1:0]  i_buffer_length,
    bbfr_in_if.sink           i_in,
    bbfr_out_if.source        o_out,
    output logic              o_mem_en,
    output logic              o_mem_we,
    output logic [AW-1:0]     o_mem_addr,
    output logic [BYTE_W-1:0] o_mem_wdata,
    input  logic [BYTE_W-1:0] i_mem_rdata
);

    t_state              r_state, n_state;
    logic [MODE_W-1:0]   r_mode, n_mode;
    logic [LADDR_W-1:0]  r_addr, n_addr;
    logic [BYTE_W-1:0]   r_byte, n_byte;
    logic [LEN_W-1:0]    r_cursor, n_cursor;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic [VALUE_W-1:0]  r_acc, n_acc;
    t_status             r_status, n_status;
    logic                r_first_big, n_first_big;
    logic                r_out_valid, n_out_valid;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [LEN_W-1:0]    r_out_cursor, n_out_cursor;

    logic [LEN_W-1:0]    valid_len;
    logic [LEN_W-1:0]    bytes_left;
    logic [COUNT_W-1:0]  need;
    logic                fixed_ok;
    logic                load_in_range;
    logic                is_varint;
    logic                out_take;
    logic                accept;

    assign accept        = i_in.valid && i_in.ready;
    assign valid_len     = (32'(i_buffer_length) < STORE_DEPTH) ? i_buffer_length
                                                                : LEN_W'(STORE_DEPTH);
    assign bytes_left    = (valid_len > r_cursor) ? valid_len - r_cursor : '0;
    assign load_in_range = 32'(r_addr) < STORE_DEPTH;
    assign is_varint     = (r_mode == MODE_VARINT);
    assign out_take      = !r_out_valid || o_out.ready;
    assign fixed_ok      = bytes_left >= LEN_W'(need);

    always_comb begin
        case (r_mode)
            MODE_U8:  need = 3'd1;
            MODE_U16: need = 3'd2;
            MODE_U32: need = 3'd4;
            default:  need = 3'd0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_START;
            end
            S_START: begin
                case (r_mode)
                    MODE_U8, MODE_U16, MODE_U32: n_state = fixed_ok ? S_READ : S_DONE;
                    MODE_VARINT: n_state = (bytes_left != '0) ? S_READ : S_DONE;
                    default: n_state = S_DONE;
                endcase
            end
            S_READ: begin
                if (is_varint) begin
                    if (!i_mem_rdata[7] || r_count == VARINT_LAST || bytes_left == '0) begin
                        n_state = S_DONE;
                    end
                end else if (r_count == 3'd1) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_mode       = r_mode;
        n_addr       = r_addr;
        n_byte       = r_byte;
        n_cursor     = r_cursor;
        n_count      = r_count;
        n_acc        = r_acc;
        n_status     = r_status;
        n_first_big  = r_first_big;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_cursor = r_out_cursor;
        o_mem_en     = 1'b0;
        o_mem_we     = 1'b0;
        o_mem_addr   = AW'(r_cursor);
        o_mem_wdata  = r_byte;
        i_in.ready   = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode = i_in.mode;
                    n_addr = i_in.load_address;
                    n_byte = i_in.load_byte;
                end
            end
            S_START: begin
                n_acc       = '0;
                n_status    = ST_OK;
                n_count     = '0;
                n_first_big = 1'b0;
                case (r_mode)
                    MODE_LOAD: begin
                        o_mem_en   = load_in_range;
                        o_mem_we   = 1'b1;
                        o_mem_addr = AW'(r_addr);
                    end
                    MODE_REWIND: begin
                        n_cursor = '0;
                    end
                    MODE_U8, MODE_U16, MODE_U32: begin
                        if (fixed_ok) begin
                            o_mem_en = 1'b1;
                            n_cursor = r_cursor + 1'b1;
                            n_count  = need;
                        end else begin
                            n_status = ST_EOB;
                        end
                    end
                    MODE_VARINT: begin
                        if (bytes_left != '0) begin
                            o_mem_en = 1'b1;
                            n_cursor = r_cursor + 1'b1;
                        end else begin
                            n_status = ST_EOB;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_READ: begin
                if (is_varint) begin
                    n_acc = {r_acc[VALUE_W-8:0], i_mem_rdata[6:0]};
                    if (r_count == '0) n_first_big = (i_mem_rdata[6:4] != 3'd0);
                    if (!i_mem_rdata[7]) begin
                        n_status = (r_count == VARINT_LAST && r_first_big) ? ST_OVERFLOW
                                                                           : ST_OK;
                    end else if (r_count == VARINT_LAST) begin
                        n_status = ST_TOO_LONG;
                    end else if (bytes_left == '0) begin
                        n_status = ST_EOB;
                    end else begin
                        o_mem_en = 1'b1;
                        n_cursor = r_cursor + 1'b1;
                        n_count  = r_count + 1'b1;
                    end
                end else begin
                    n_acc   = {r_acc[VALUE_W-BYTE_W-1:0], i_mem_rdata};
                    n_count = r_count - 1'b1;
                    if (r_count != 3'd1) begin
                        o_mem_en = 1'b1;
                        n_cursor = r_cursor + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_take) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = (r_status == ST_OK) ? r_acc : '0;
                    n_out_status = r_status;
                    n_out_cursor = r_cursor;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_addr       <= n_addr;
        r_byte       <= n_byte;
        r_count      <= n_count;
        r_acc        <= n_acc;
        r_status     <= n_status;
        r_first_big  <= n_first_big;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_cursor <= n_out_cursor;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.read_value   = r_out_value;
    assign o_out.status       = r_out_status;
    assign o_out.cursor_after = r_out_cursor;

`ifndef SYNTHESIS
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result raised outside done state");

    a_cursor_moves_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_cursor)) |->
        ($past(r_state) == S_START || $past(r_state) == S_READ))
        else $error("cursor moved outside a fetch");

    a_fixed_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && !is_varint) |-> r_count != '0)
        else $error("fixed read with no bytes pending");

    a_read_on_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_en && !o_mem_we) |=> r_state == S_READ)
        else $error("store read not followed by data use");
`endif

endmodule

// ===== rtl/core/byte_buffer_field_reader.sv =====
// Byte buffer field reader: top level with length register, sequencer and byte store.
//
// Bytes are written into a single-port store by load transactions; the length register
// marks how many of them, from position zero, may be read. Read transactions take an
// unsigned byte, a big-endian 16- or 32-bit word, or an MSB-first 7-bit-group varint of up
// to five bytes at the read cursor; rewind returns the cursor to zero. Every transaction
// gives one result. One transaction is handled at a time: from acceptance it passes through
// the start state, the read state once for each byte fetched and the done state, where its
// result is registered. No bytes are fetched for load, rewind, unused modes and failed fixed
// reads, 1/2/4 for fixed reads and 0 to 5 for varints; the store has one port and delivers
// one byte per cycle. A new transaction is accepted the cycle after a result is registered,
// even while that result still waits. The store has no reset and needs no clearing pass;
// bytes must be loaded before they are read. Length writes are taken at any time but
// should come while the block is idle.
module byte_buffer_field_reader import bbfr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbfr_in_if.sink    i_in,
    bbfr_out_if.source o_out,
    bbfr_cfg_if.sink   i_cfg
);

    localparam int AW = $clog2(STORE_DEPTH);

    logic [LEN_W-1:0]  r_buffer_length;
    logic              mem_en;
    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_length <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_buffer_length <= i_cfg.data;
        end
    end

    bbfr_ctrl #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_buffer_length (r_buffer_length),
        .i_in            (i_in),
        .o_out           (o_out),
        .o_mem_en        (mem_en),
        .o_mem_we        (mem_we),
        .o_mem_addr      (mem_addr),
        .o_mem_wdata     (mem_wdata),
        .i_mem_rdata     (mem_rdata)
    );

    bbfr_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

endmodule
